FILE: design/tpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpu_pkg
// Shared types and constants of the tracker pattern unpacker: event kinds,
// the packed event record, command codes and register addresses.
// ----------------------------------------------------------------------------
package tpu_pkg;

  typedef enum logic [3:0] {
    EV_NOTE       = 4'd0,
    EV_KEYOFF     = 4'd1,
    EV_INSTRUMENT = 4'd2,
    EV_VOLUME     = 4'd3,
    EV_PAN        = 4'd4,
    EV_NOTE_DELAY = 4'd5,
    EV_EFFECT     = 4'd6,
    EV_PORTAMENTO = 4'd7,
    EV_DONE       = 4'd8
  } event_kind_t;

  // packed from the lowest bit: kind, row, channel, value, effect_parameter
  typedef struct packed {
    logic [7:0]  effect_parameter;
    logic [7:0]  value;
    logic [4:0]  channel;
    logic [5:0]  row;
    event_kind_t kind;
  } event_t;

  localparam int EVENT_W = $bits(event_t);
  localparam int KIND_W  = $bits(event_kind_t);
  // the kind travels as tuser, the rest of the record as tdata
  localparam int EVENT_TDATA_W = ((EVENT_W - KIND_W + 7) / 8) * 8;

  localparam logic [7:0] SKIP_ROW_BYTE      = 8'hff;
  localparam logic [5:0] CMD_TONE_PORTA     = 6'h03;
  localparam logic [5:0] CMD_TONE_PORTA_VOL = 6'h05;
  localparam logic [5:0] CMD_PAN            = 6'h08;
  localparam logic [5:0] CMD_VOLUME         = 6'h0c;
  localparam logic [5:0] CMD_EXTENDED       = 6'h0e;
  localparam logic [5:0] CMD_TONE_PORTA_ALT = 6'h15;
  localparam logic [3:0] EXT_NOTE_DELAY     = 4'hd;

  localparam logic [7:0] NOTE_OFFSET_RESET = 8'd24;

  // register select is address bit 2
  localparam logic REG_NOTE_OFFSET = 1'b0;
  localparam logic REG_KEYOFF      = 1'b1;

  function automatic event_t make_event(
    input event_kind_t kind,
    input logic [5:0]  row,
    input logic [4:0]  channel,
    input logic [7:0]  value,
    input logic [7:0]  effect_parameter
  );
    event_t e;
    e.kind             = kind;
    e.row              = row;
    e.channel          = channel;
    e.value            = value;
    e.effect_parameter = effect_parameter;
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: design/tracker_pattern_unpacker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tracker_pattern_unpacker_unit
// Unpacks packed tracker pattern bytes into row/channel tagged cell events.
// ----------------------------------------------------------------------------
// One pattern byte is parsed per cycle as long as the output takes the events
// of the byte before: the parse state and the per-channel effect counters
// update at the edge that takes the byte, and its zero to three events land
// together in a three-slot result register that drains one event per cycle
// while m_axis_tready is high. The next byte is taken in the same cycle as the
// last event of the previous one. Assert tuser with the first byte of each
// pattern.
module tracker_pattern_unpacker_unit #(
  parameter int ROWS             = 64,
  parameter int CHANNELS         = 32,
  parameter int EFFECTS_PER_CELL = 4,
  parameter int LENGTH_BITS      = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // pattern_length, data_byte
  input  wire logic [((LENGTH_BITS + 15) / 8) * 8 - 1:0] s_axis_tdata,
  // start_req
  input  wire logic                                  s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // row, channel, value, effect_parameter
  output logic [tpu_pkg::EVENT_TDATA_W-1:0]          m_axis_tdata,
  // event_kind
  output logic [tpu_pkg::KIND_W-1:0]                 m_axis_tuser,
  output logic                                       m_axis_tlast,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [2:0]                            paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  localparam int RowW = $clog2(ROWS + 1);
  localparam int FxW  = $clog2(EFFECTS_PER_CELL + 1);
  localparam int ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [RowW-1:0] RowLimit = RowW'(ROWS);
  localparam logic [RowW-1:0] RowLast  = RowW'(ROWS - 1);
  localparam logic [FxW-1:0]  FxLimit  = FxW'(EFFECTS_PER_CELL);
  localparam logic [5:0]      ChLimit  = 6'(CHANNELS);
  localparam logic [LENGTH_BITS+1:0] LenThree = (LENGTH_BITS + 2)'(3);

  typedef enum logic [2:0] {
    PH_HEAD  = 3'd0,
    PH_FIRST = 3'd1,
    PH_INSTR = 3'd2,
    PH_CMD   = 3'd3,
    PH_PARAM = 3'd4,
    PH_IDLE  = 3'd5
  } phase_t;

  // configuration
  logic [7:0] note_offset;
  logic       keyoff_on_note_one;

  // parse state
  phase_t                 phase;
  logic [7:0]             header_byte;
  logic [7:0]             held_byte;
  logic [RowW-1:0]        current_row;
  logic [LENGTH_BITS-1:0] bytes_seen;
  logic [LENGTH_BITS-1:0] bytes_total;
  logic                   finished;
  logic [FxW-1:0]         effects_in_cell [CHANNELS];

  // result register
  tpu_pkg::event_t ev_q [3];
  logic [1:0]      ev_cnt;
  logic [1:0]      ev_idx;
  tpu_pkg::event_t ev_out;

  logic                   start_req;
  logic [LENGTH_BITS-1:0] pattern_length;
  logic [7:0]             data_byte;
  logic                   s_acc;
  logic                   m_acc;
  logic                   out_last;

  phase_t                 eff_phase;
  logic [7:0]             eff_header;
  logic [7:0]             eff_held;
  logic [RowW-1:0]        eff_row;
  logic [LENGTH_BITS-1:0] eff_seen;
  logic [LENGTH_BITS-1:0] eff_total;
  logic                   eff_finished;
  logic [FxW-1:0]         eff_fx;
  logic [ChW-1:0]         ch_idx;
  logic                   live;
  logic                   active;
  logic [LENGTH_BITS-1:0] seen_inc;
  logic [6:0]             note_num;
  logic [5:0]             cmd;

  phase_t                 phase_next;
  logic [7:0]             header_byte_next;
  logic [7:0]             held_byte_next;
  logic [RowW-1:0]        current_row_next;
  logic [LENGTH_BITS-1:0] bytes_seen_next;
  logic                   finished_next;
  logic                   adv;
  logic                   fx_inc;
  logic                   do_cmd;
  logic                   do_end;
  tpu_pkg::event_t        cand [3];
  logic [2:0]             cand_v;
  tpu_pkg::event_t        ev_next [3];
  logic [1:0]             ev_cnt_next;

  assign start_req      = s_axis_tuser;
  assign pattern_length = s_axis_tdata[LENGTH_BITS-1:0];
  assign data_byte      = s_axis_tdata[LENGTH_BITS+7:LENGTH_BITS];

  assign ev_out        = ev_q[ev_idx];
  assign out_last      = (ev_idx == (ev_cnt - 2'd1));
  assign m_axis_tvalid = (ev_cnt != 2'd0);
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = ev_out.kind;
  assign m_axis_tdata  = tpu_pkg::EVENT_TDATA_W'(ev_out[tpu_pkg::EVENT_W-1:tpu_pkg::KIND_W]);
  assign m_acc         = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (ev_cnt == 2'd0) || (m_acc && out_last);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tpu_pkg::REG_KEYOFF) ? {31'd0, keyoff_on_note_one}
                                                     : {24'd0, note_offset};

  always_comb begin
    eff_phase    = start_req ? PH_HEAD : phase;
    eff_header   = start_req ? 8'd0 : header_byte;
    eff_held     = start_req ? 8'd0 : held_byte;
    eff_row      = start_req ? '0 : current_row;
    eff_seen     = start_req ? '0 : bytes_seen;
    eff_total    = start_req ? pattern_length : bytes_total;
    eff_finished = start_req ? 1'b0 : finished;
    ch_idx       = eff_header[ChW-1:0];
    eff_fx       = start_req ? '0 : effects_in_cell[ch_idx];
    live         = !eff_header[5] && ({1'b0, eff_header[4:0]} < ChLimit);
    active       = !eff_finished && (eff_seen < eff_total);
    seen_inc     = eff_seen + LENGTH_BITS'(1);
    note_num     = eff_held[6:0];
    cmd          = eff_held[5:0];

    phase_next       = eff_phase;
    header_byte_next = eff_header;
    held_byte_next   = eff_held;
    bytes_seen_next  = eff_seen;
    finished_next    = eff_finished;
    adv              = 1'b0;
    fx_inc           = 1'b0;
    do_cmd           = 1'b0;
    do_end           = 1'b0;
    cand_v           = 3'b000;
    for (int i = 0; i < 3; i++) begin
      cand[i] = '0;
    end

    if (active) begin
      case (eff_phase)
        PH_HEAD: begin
          if (({2'b00, eff_total} < ({2'b00, eff_seen} + LenThree)) ||
              (eff_row >= RowLimit)) begin
            phase_next = PH_IDLE;
          end else if (data_byte == tpu_pkg::SKIP_ROW_BYTE) begin
            adv = 1'b1;
          end else begin
            header_byte_next = data_byte;
            phase_next       = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (eff_header[6]) begin
            do_cmd = 1'b1;
          end else begin
            held_byte_next = data_byte;
            phase_next     = PH_INSTR;
          end
        end
        PH_INSTR: begin
          if (live) begin
            if (note_num != 7'd0) begin
              cand_v[0] = 1'b1;
              if (keyoff_on_note_one && (note_num == 7'd1)) begin
                cand[0] = tpu_pkg::make_event(tpu_pkg::EV_KEYOFF, 6'(eff_row),
                                              eff_header[4:0], 8'd0, 8'd0);
              end else begin
                cand[0] = tpu_pkg::make_event(tpu_pkg::EV_NOTE, 6'(eff_row),
                                              eff_header[4:0],
                                              {1'b0, note_num} + note_offset, 8'd0);
              end
            end
            cand_v[1] = 1'b1;
            cand[1]   = tpu_pkg::make_event(tpu_pkg::EV_INSTRUMENT, 6'(eff_row),
                                            eff_header[4:0], data_byte, 8'd0);
          end
          if (eff_held[7]) begin
            phase_next = PH_CMD;
          end else begin
            do_end = 1'b1;
          end
        end
        PH_CMD: begin
          do_cmd = 1'b1;
        end
        PH_PARAM: begin
          if (live) begin
            if ((cmd == tpu_pkg::CMD_PAN) && (data_byte[7:4] == 4'h0)) begin
              cand_v[0] = 1'b1;
              cand[0]   = tpu_pkg::make_event(tpu_pkg::EV_PAN, 6'(eff_row),
                                              eff_header[4:0], data_byte, 8'd0);
            end else if (cmd == tpu_pkg::CMD_VOLUME) begin
              cand_v[0] = 1'b1;
              cand[0]   = tpu_pkg::make_event(tpu_pkg::EV_VOLUME, 6'(eff_row),
                                              eff_header[4:0], data_byte, 8'd0);
            end else if ((cmd == tpu_pkg::CMD_EXTENDED) &&
                         (data_byte[7:4] == tpu_pkg::EXT_NOTE_DELAY)) begin
              cand_v[0] = 1'b1;
              cand[0]   = tpu_pkg::make_event(tpu_pkg::EV_NOTE_DELAY, 6'(eff_row),
                                              eff_header[4:0], {4'h0, data_byte[3:0]},
                                              8'd0);
            end else if (eff_fx < FxLimit) begin
              fx_inc    = 1'b1;
              cand_v[0] = 1'b1;
              cand[0]   = tpu_pkg::make_event(tpu_pkg::EV_EFFECT, 6'(eff_row),
                                              eff_header[4:0], {2'b00, cmd}, data_byte);
            end
            if ((cmd == tpu_pkg::CMD_TONE_PORTA) || (cmd == tpu_pkg::CMD_TONE_PORTA_VOL) ||
                (cmd == tpu_pkg::CMD_TONE_PORTA_ALT)) begin
              cand_v[1] = 1'b1;
              cand[1]   = tpu_pkg::make_event(tpu_pkg::EV_PORTAMENTO, 6'(eff_row),
                                              eff_header[4:0], 8'd0, 8'd0);
            end
          end
          if (eff_held[7]) begin
            phase_next = PH_CMD;
          end else begin
            do_end = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (do_cmd) begin
        held_byte_next = data_byte;
        if (data_byte[6]) begin
          if (live) begin
            cand_v[0] = 1'b1;
            cand[0]   = tpu_pkg::make_event(tpu_pkg::EV_VOLUME, 6'(eff_row),
                                            eff_header[4:0], {data_byte[5:0], 1'b0}, 8'd0);
          end
          if (data_byte[7]) begin
            phase_next = PH_CMD;
          end else begin
            do_end = 1'b1;
          end
        end else begin
          phase_next = PH_PARAM;
        end
      end

      if (do_end) begin
        adv        = eff_header[7];
        phase_next = PH_HEAD;
      end
    end

    current_row_next = adv ? (eff_row + RowW'(1)) : eff_row;

    if (active) begin
      bytes_seen_next = seen_inc;
      if (seen_inc == eff_total) begin
        finished_next = 1'b1;
        cand_v[2]     = 1'b1;
        cand[2]       = tpu_pkg::make_event(tpu_pkg::EV_DONE,
                          6'((current_row_next < RowLimit) ? current_row_next : RowLast),
                          5'd0, 8'd0, 8'd0);
      end
    end

    ev_cnt_next = 2'd0;
    for (int i = 0; i < 3; i++) begin
      ev_next[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      if (cand_v[i]) begin
        ev_next[ev_cnt_next] = cand[i];
        ev_cnt_next          = ev_cnt_next + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_offset        <= tpu_pkg::NOTE_OFFSET_RESET;
      keyoff_on_note_one <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == tpu_pkg::REG_NOTE_OFFSET) begin
        note_offset <= pwdata[7:0];
      end else begin
        keyoff_on_note_one <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEAD;
      header_byte <= 8'd0;
      held_byte   <= 8'd0;
      current_row <= '0;
      bytes_seen  <= '0;
      bytes_total <= '0;
      finished    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        effects_in_cell[i] <= '0;
      end
    end else if (s_acc) begin
      phase       <= phase_next;
      header_byte <= header_byte_next;
      held_byte   <= held_byte_next;
      current_row <= current_row_next;
      bytes_seen  <= bytes_seen_next;
      bytes_total <= eff_total;
      finished    <= finished_next;
      if (start_req || adv) begin
        for (int i = 0; i < CHANNELS; i++) begin
          effects_in_cell[i] <= '0;
        end
      end else if (fx_inc) begin
        effects_in_cell[ch_idx] <= eff_fx + FxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_cnt <= 2'd0;
      ev_idx <= 2'd0;
    end else if (s_acc) begin
      ev_cnt <= ev_cnt_next;
      ev_idx <= 2'd0;
    end else if (m_acc) begin
      if (out_last) begin
        ev_cnt <= 2'd0;
        ev_idx <= 2'd0;
      end else begin
        ev_idx <= ev_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      for (int i = 0; i < 3; i++) begin
        ev_q[i] <= ev_next[i];
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (ev_cnt != 2'd0) |-> (ev_idx < ev_cnt))
    else $error("result index beyond result count");

  a_accept_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (ev_cnt != 2'd0)) |-> (m_acc && out_last))
    else $error("byte taken while results still pending");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (ev_q[ev_idx].kind == tpu_pkg::EV_DONE)) |-> m_axis_tlast)
    else $error("done event not last of its byte");

  a_finished_holds: assert property (@(posedge clk) disable iff (rst)
    (finished && !(s_acc && start_req)) |=> finished)
    else $error("finished flag dropped without a new pattern");

  a_row_bounded: assert property (@(posedge clk) disable iff (rst)
    current_row <= RowLimit)
    else $error("row counter beyond row limit");

endmodule
`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tracker pattern unpacker.
// Packed pattern bytes go in over the input stream. A parser kept in the
// bench works out the cell events of every byte it hands over, and each
// output transaction is compared field by field, in order, with the oldest
// event still owed. Directed patterns cover every command form and the rules
// at the end of a pattern. Random patterns then run under several sender and
// receiver idle mixes, and under one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS             = 64;
  localparam int CHANNELS         = 32;
  localparam int EFFECTS_PER_CELL = 4;
  localparam int LENGTH_BITS      = 16;
  localparam int S_TDATA_W        = ((LENGTH_BITS + 15) / 8) * 8;
  localparam int PAYLOAD_W        = tpu_pkg::EVENT_W - tpu_pkg::KIND_W;
  localparam int SETTLE_CYCLES    = 16;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int REPORT_LINES     = 40;

  typedef enum logic [2:0] {
    PARSE_HEAD,
    PARSE_NOTE,
    PARSE_INSTR,
    PARSE_CMD,
    PARSE_PARAM,
    PARSE_IDLE
  } parse_phase_t;

  typedef struct {
    tpu_pkg::event_t ev;
    logic            last;
  } owed_event_t;

  logic                               clk           = 1'b0;
  logic                               rst           = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [S_TDATA_W-1:0]               s_axis_tdata  = '0;
  logic                               s_axis_tuser  = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [tpu_pkg::EVENT_TDATA_W-1:0]  m_axis_tdata;
  logic [tpu_pkg::KIND_W-1:0]         m_axis_tuser;
  logic                               m_axis_tlast;
  logic                               psel          = 1'b0;
  logic                               penable       = 1'b0;
  logic                               pwrite        = 1'b0;
  logic [2:0]                         paddr         = '0;
  logic [31:0]                        pwdata        = '0;
  logic [31:0]                        prdata;
  logic                               pready;

  // parser state of the bench
  parse_phase_t  parse_phase   = PARSE_HEAD;
  logic [7:0]    chunk_header  = '0;
  logic [7:0]    pending_byte  = '0;
  int unsigned   row_count     = 0;
  int            bytes_taken   = 0;
  logic [15:0]   pattern_total = '0;
  int unsigned   effect_count[CHANNELS];
  bit            pattern_over  = 1'b0;
  logic [7:0]    cfg_note_offset   = tpu_pkg::NOTE_OFFSET_RESET;
  logic          cfg_keyoff_on_one = 1'b0;

  tpu_pkg::event_t byte_events[$];
  owed_event_t     owed_events[$];
  logic [7:0]      pattern_bytes[$];

  int            mismatches      = 0;
  int            items_sent      = 0;
  int            send_idle_pct   = 0;
  int            recv_stall_pct  = 0;
  bit            hold_off_toggle = 1'b0;
  bit            hold_off_seen   = 1'b0;
  int            hold_off_left   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tracker_pattern_unpacker_unit #(
    .ROWS             (ROWS),
    .CHANNELS         (CHANNELS),
    .EFFECTS_PER_CELL (EFFECTS_PER_CELL),
    .LENGTH_BITS      (LENGTH_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // pattern_length, data_byte
    .s_axis_tdata  (s_axis_tdata),
    // start_req
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // row, channel, value, effect_parameter
    .m_axis_tdata  (m_axis_tdata),
    // event_kind
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    foreach (effect_count[i]) effect_count[i] = 0;
  end

  // ---------------------------------------------------------------- parser
  function automatic bit channel_live();
    return !chunk_header[5] && int'(chunk_header[4:0]) < CHANNELS;
  endfunction

  function automatic void add_event(tpu_pkg::event_kind_t kind, logic [5:0] row,
                                    logic [4:0] chan, logic [7:0] val, logic [7:0] par);
    tpu_pkg::event_t e;
    e.kind             = kind;
    e.row              = row;
    e.channel          = chan;
    e.value            = val;
    e.effect_parameter = par;
    byte_events.push_back(e);
  endfunction

  function automatic void add_cell_event(tpu_pkg::event_kind_t kind, logic [7:0] val,
                                         logic [7:0] par);
    add_event(kind, row_count[5:0], chunk_header[4:0], val, par);
  endfunction

  function automatic void advance_row();
    row_count++;
    foreach (effect_count[i]) effect_count[i] = 0;
  endfunction

  function automatic void close_chunk();
    if (chunk_header[7]) advance_row();
    parse_phase = PARSE_HEAD;
  endfunction

  function automatic void take_command(logic [7:0] c);
    pending_byte = c;
    if (c[6]) begin
      if (channel_live()) add_cell_event(tpu_pkg::EV_VOLUME, {c[5:0], 1'b0}, 8'h00);
      if (c[7]) parse_phase = PARSE_CMD;
      else close_chunk();
    end else begin
      parse_phase = PARSE_PARAM;
    end
  endfunction

  function automatic void take_parameter(logic [7:0] p);
    logic [5:0] cmd;
    int         ch;
    cmd = pending_byte[5:0];
    ch  = int'(chunk_header[4:0]);
    if (channel_live()) begin
      if (cmd == tpu_pkg::CMD_PAN && p[7:4] == 4'h0) begin
        add_cell_event(tpu_pkg::EV_PAN, p, 8'h00);
      end else if (cmd == tpu_pkg::CMD_VOLUME) begin
        add_cell_event(tpu_pkg::EV_VOLUME, p, 8'h00);
      end else if (cmd == tpu_pkg::CMD_EXTENDED && p[7:4] == tpu_pkg::EXT_NOTE_DELAY) begin
        add_cell_event(tpu_pkg::EV_NOTE_DELAY, {4'h0, p[3:0]}, 8'h00);
      end else if (effect_count[ch] < EFFECTS_PER_CELL) begin
        effect_count[ch]++;
        add_cell_event(tpu_pkg::EV_EFFECT, {2'b00, cmd}, p);
      end
      if (cmd == tpu_pkg::CMD_TONE_PORTA || cmd == tpu_pkg::CMD_TONE_PORTA_VOL ||
          cmd == tpu_pkg::CMD_TONE_PORTA_ALT)
        add_cell_event(tpu_pkg::EV_PORTAMENTO, 8'h00, 8'h00);
    end
    if (pending_byte[7]) parse_phase = PARSE_CMD;
    else close_chunk();
  endfunction

  function automatic void predict_byte(bit start, logic [15:0] len, logic [7:0] b);
    int         pos;
    logic [6:0] nn;
    logic [5:0] done_row;
    owed_event_t o;
    byte_events.delete();
    if (start) begin
      parse_phase   = PARSE_HEAD;
      chunk_header  = '0;
      pending_byte  = '0;
      row_count     = 0;
      bytes_taken   = 0;
      pattern_total = len;
      foreach (effect_count[i]) effect_count[i] = 0;
      pattern_over  = 1'b0;
    end
    if (pattern_over || bytes_taken >= int'(pattern_total)) return;
    pos = bytes_taken;
    case (parse_phase)
      PARSE_HEAD: begin
        if (int'(pattern_total) < pos + 3 || row_count >= ROWS) parse_phase = PARSE_IDLE;
        else if (b == tpu_pkg::SKIP_ROW_BYTE) advance_row();
        else begin
          chunk_header = b;
          parse_phase  = PARSE_NOTE;
        end
      end
      PARSE_NOTE: begin
        if (chunk_header[6]) take_command(b);
        else begin
          pending_byte = b;
          parse_phase  = PARSE_INSTR;
        end
      end
      PARSE_INSTR: begin
        if (channel_live()) begin
          nn = pending_byte[6:0];
          if (nn != 7'd0) begin
            if (cfg_keyoff_on_one && nn == 7'd1)
              add_cell_event(tpu_pkg::EV_KEYOFF, 8'h00, 8'h00);
            else
              add_cell_event(tpu_pkg::EV_NOTE, {1'b0, nn} + cfg_note_offset, 8'h00);
          end
          add_cell_event(tpu_pkg::EV_INSTRUMENT, b, 8'h00);
        end
        if (pending_byte[7]) parse_phase = PARSE_CMD;
        else close_chunk();
      end
      PARSE_CMD:   take_command(b);
      PARSE_PARAM: take_parameter(b);
      default: ;
    endcase
    if (pos + 1 == int'(pattern_total)) begin
      done_row = row_count < ROWS ? row_count[5:0] : 6'(ROWS - 1);
      add_event(tpu_pkg::EV_DONE, done_row, 5'd0, 8'h00, 8'h00);
      pattern_over = 1'b1;
    end
    bytes_taken = pos + 1;
    foreach (byte_events[i]) begin
      o.ev   = byte_events[i];
      o.last = (i == byte_events.size() - 1);
      owed_events.push_back(o);
    end
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LINES) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    owed_event_t     want;
    tpu_pkg::event_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = tpu_pkg::event_t'({m_axis_tdata[PAYLOAD_W-1:0], m_axis_tuser});
      if (owed_events.size() == 0) begin
        report_mismatch($sformatf("event %0h/%0h with nothing owed", m_axis_tuser,
                                  m_axis_tdata));
      end else begin
        want = owed_events.pop_front();
        check_field("kind", 8'(got.kind), 8'(want.ev.kind));
        check_field("row", 8'(got.row), 8'(want.ev.row));
        check_field("channel", 8'(got.channel), 8'(want.ev.channel));
        check_field("value", got.value, want.ev.value);
        check_field("effect_parameter", got.effect_parameter, want.ev.effect_parameter);
        check_field("last", 8'(m_axis_tlast), 8'(want.last));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off_seen != hold_off_toggle) begin
      hold_off_seen = hold_off_toggle;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(bit start, logic [15:0] len, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= {data, len};
    do @(posedge clk); while (!s_axis_tready);
    predict_byte(start, len, data);
    items_sent++;
  endtask

  task automatic send_pattern(logic [15:0] len);
    foreach (pattern_bytes[i])
      send_byte(i == 0, i == 0 ? len : 16'($urandom), pattern_bytes[i]);
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (owed_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic sel, logic [7:0] value);
    logic [31:0] word;
    word       = $urandom();
    word[7:0]  = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (sel == tpu_pkg::REG_NOTE_OFFSET) cfg_note_offset = value;
    else cfg_keyoff_on_one = value[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (sel == tpu_pkg::REG_NOTE_OFFSET)
      check_field("note_offset readback", prdata[7:0], value);
    else
      check_field("keyoff readback", {7'b0, prdata[0]}, {7'b0, value[0]});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------- pattern builders
  function automatic logic [5:0] pick_command();
    case ($urandom_range(7))
      0: return tpu_pkg::CMD_TONE_PORTA;
      1: return tpu_pkg::CMD_TONE_PORTA_VOL;
      2: return tpu_pkg::CMD_PAN;
      3: return tpu_pkg::CMD_VOLUME;
      4: return tpu_pkg::CMD_EXTENDED;
      5: return tpu_pkg::CMD_TONE_PORTA_ALT;
      default: return 6'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_parameter(logic [5:0] cmd);
    if ($urandom_range(1) == 0) return 8'($urandom);
    if (cmd == tpu_pkg::CMD_PAN) return {4'h0, 4'($urandom)};
    if (cmd == tpu_pkg::CMD_EXTENDED) return {tpu_pkg::EXT_NOTE_DELAY, 4'($urandom)};
    return 8'($urandom);
  endfunction

  function automatic void add_random_chunk(bit row_end);
    logic [4:0] ch;
    logic [6:0] nn;
    logic [5:0] cmd;
    bit         midi;
    bit         cmd_only;
    bit         more;
    int         ncmd;
    ch       = $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom);
    midi     = ($urandom_range(7) == 0);
    cmd_only = $urandom_range(1);
    ncmd     = $urandom_range(cmd_only ? 1 : 0, 3);
    pattern_bytes.push_back({row_end, cmd_only, midi, ch});
    if (!cmd_only) begin
      case ($urandom_range(5))
        0:       nn = 7'd0;
        1:       nn = 7'd1;
        default: nn = 7'($urandom);
      endcase
      pattern_bytes.push_back({ncmd > 0, nn});
      pattern_bytes.push_back(8'($urandom));
    end
    for (int i = 0; i < ncmd; i++) begin
      more = (i < ncmd - 1);
      if ($urandom_range(2) == 0) begin
        pattern_bytes.push_back({more, 1'b1, 6'($urandom)});
      end else begin
        cmd = pick_command();
        pattern_bytes.push_back({more, 1'b0, cmd});
        pattern_bytes.push_back(pick_parameter(cmd));
      end
    end
  endfunction

  function automatic void build_cell_pattern();
    int rows;
    int chunks;
    pattern_bytes.delete();
    rows = $urandom_range(9) == 0 ? $urandom_range(8, 16) : $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(5) == 0) begin
        pattern_bytes.push_back(tpu_pkg::SKIP_ROW_BYTE);
      end else begin
        chunks = $urandom_range(1, 3);
        for (int c = 0; c < chunks; c++) add_random_chunk(c == chunks - 1);
      end
    end
    if ($urandom_range(3) == 0) add_random_chunk(1'b0);
  endfunction

  function automatic void build_noise_pattern();
    pattern_bytes.delete();
    repeat ($urandom_range(3, 20)) pattern_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] pick_length(int size);
    case ($urandom_range(19))
      0, 1, 2: return size > 1 ? 16'(size - $urandom_range(1, size > 4 ? 4 : size - 1))
                               : 16'(size);
      3, 4:    return 16'(size + $urandom_range(1, 3));
      5:       return 16'd0;
      6:       return 16'($urandom);
      default: return 16'(size);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_cell_commands();
    // ignored: no pattern started yet
    send_byte(1'b0, 16'hffff, 8'h00);
    send_byte(1'b0, 16'h0000, 8'hff);
    pattern_bytes = '{8'h85, 8'hff, 8'hff, 8'hff, 8'h88, 8'h0f, 8'h8c, 8'hab,
                      8'h8e, 8'hd7, 8'h8e, 8'h31, 8'h83, 8'h10, 8'h95, 8'h00,
                      8'h88, 8'hf0, 8'h81, 8'h22, 8'h05, 8'hff};
    send_pattern(16'(pattern_bytes.size()));
    wait_for_idle();
  endtask

  task automatic test_chunk_forms();
    pattern_bytes = '{8'hff, 8'h5f, 8'h00, 8'h00, 8'he0, 8'h7f,
                      8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    send_pattern(16'(pattern_bytes.size()));
    wait_for_idle();
  endtask

  task automatic test_truncated_patterns();
    pattern_bytes = '{8'h02, 8'h90, 8'h33, 8'h08, 8'h05};
    send_pattern(16'd4);
    pattern_bytes = '{8'h85, 8'h00};
    send_pattern(16'd0);
    pattern_bytes = '{8'h85};
    send_pattern(16'd1);
    wait_for_idle();
  endtask

  task automatic test_row_limit();
    pattern_bytes.delete();
    repeat (ROWS - 1) pattern_bytes.push_back(tpu_pkg::SKIP_ROW_BYTE);
    pattern_bytes.push_back(8'h83);
    pattern_bytes.push_back(8'h2a);
    pattern_bytes.push_back(8'h01);
    repeat (3) pattern_bytes.push_back(8'h00);
    send_pattern(16'(pattern_bytes.size()));
    wait_for_idle();
  endtask

  task automatic test_note_registers();
    write_register(tpu_pkg::REG_NOTE_OFFSET, 8'd128);
    write_register(tpu_pkg::REG_KEYOFF, 8'd1);
    pattern_bytes = '{8'h04, 8'h01, 8'h10, 8'h84, 8'h7f, 8'h20};
    send_pattern(16'd6);
    wait_for_idle();
    write_register(tpu_pkg::REG_NOTE_OFFSET, 8'hff);
    write_register(tpu_pkg::REG_KEYOFF, 8'd0);
    send_pattern(16'd6);
    wait_for_idle();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, logic [7:0] offset,
                                     logic keyoff, int item_count);
    int target;
    write_register(tpu_pkg::REG_NOTE_OFFSET, offset);
    write_register(tpu_pkg::REG_KEYOFF, {7'b0, keyoff});
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + item_count;
    while (items_sent < target) begin
      if ($urandom_range(7) == 0) build_noise_pattern();
      else build_cell_pattern();
      send_pattern(pick_length(pattern_bytes.size()));
      if ($urandom_range(7) == 0)
        repeat ($urandom_range(1, 3)) send_byte(1'b0, 16'($urandom), 8'($urandom));
    end
    wait_for_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_off_toggle = !hold_off_toggle;
    @(posedge clk);
    repeat (4) begin
      build_cell_pattern();
      send_pattern(16'(pattern_bytes.size()));
    end
    wait_for_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_cell_commands();
    test_chunk_forms();
    test_truncated_patterns();
    test_row_limit();
    test_note_registers();
    test_random_traffic(0, 0, 8'd0, 1'b0, 45);
    test_random_traffic(68, 0, 8'd128, 1'b1, 45);
    test_random_traffic(0, 68, 8'($urandom_range(128)), 1'($urandom), 45);
    test_random_traffic(7, 7, tpu_pkg::NOTE_OFFSET_RESET, 1'b0, 45);
    test_backpressure();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: tracker_pattern_unpacker_unit.f
design/tpu_pkg.sv
design/tracker_pattern_unpacker_unit.sv
sim/tb.sv
